[rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries assertions.
// Depends on nothing; expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define B2DA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("b2da assertion failed");

// Implication whose consequent must hold in the cycle after its trigger.
`define B2DA_ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("b2da assertion failed");

`endif

[rtl/b2da_pkg.sv]
// Package for the binary to decimal ASCII converter: payload types, constants,
// controller state type and the command/status structs. Depends on nothing.
package b2da_pkg;

  localparam int MAG_W       = 32;
  localparam int HW_DIGITS   = 10;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int DEF_MAX_DIGITS = 10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;

  typedef struct packed {
    logic             action;
    logic [MAG_W-1:0] magnitude;
  } num_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } glyph_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;        // capture a new number
    logic shift_bit;   // one double-dabble step
    logic skip_zero;   // drop a leading zero digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the top digit into the output register
  } cmd_t;

  typedef struct packed {
    logic conv_done;   // last double-dabble step is under way
    logic can_skip;    // top digit is a leading zero that may be dropped
    logic one_left;    // only one digit remains to be emitted
    logic out_free;    // output register can take a character this cycle
    logic negative;    // number carries a minus sign
  } status_t;

endpackage

[rtl/b2da_datapath.sv]
// Datapath of the converter: shift register, BCD register with add-3 adjust,
// digit counter and the output register. Uses b2da_pkg.
module b2da_datapath #(
  parameter int NUM_DIGITS = b2da_pkg::HW_DIGITS
) (
  input  logic               clk,
  input  logic               rst,
  input  b2da_pkg::num_t     num,
  input  b2da_pkg::cmd_t     cmd,
  output b2da_pkg::status_t  status,
  output logic               glyph_valid,
  input  logic               glyph_stall,
  output b2da_pkg::glyph_t   glyph
);

  localparam int BCD_W = NUM_DIGITS * b2da_pkg::DIGIT_W;
  localparam int CNT_W = $clog2(NUM_DIGITS + 1);
  localparam int BIT_W = $clog2(b2da_pkg::MAG_W);

  logic [b2da_pkg::MAG_W-1:0] shreg;
  logic [BCD_W-1:0]           bcd;
  logic [BCD_W-1:0]           bcd_adj;
  logic                       ovf;
  logic                       negative;
  logic [BIT_W-1:0]           bitcnt;
  logic [CNT_W-1:0]           remaining;
  logic [b2da_pkg::DIGIT_W-1:0] top_digit;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= 4'd5) begin
        bcd_adj[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
          bcd[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
          bcd[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
      end
    end
  end

  assign top_digit = bcd[BCD_W-1 -: b2da_pkg::DIGIT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      glyph_valid <= 1'b1;
    end else if (!glyph_stall) begin
      glyph_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg     <= num.magnitude;
      negative  <= num.action;
      bcd       <= '0;
      ovf       <= 1'b0;
      bitcnt    <= '0;
      remaining <= CNT_W'(NUM_DIGITS);
    end else if (cmd.shift_bit) begin
      shreg  <= shreg << 1;
      bcd    <= {bcd_adj[BCD_W-2:0], shreg[b2da_pkg::MAG_W-1]};
      // A carry out of the top digit means the value has more digits than fit.
      ovf    <= ovf | bcd_adj[BCD_W-1];
      bitcnt <= bitcnt + BIT_W'(1);
    end else if (cmd.skip_zero || cmd.emit_digit) begin
      bcd       <= bcd << b2da_pkg::DIGIT_W;
      remaining <= remaining - CNT_W'(1);
    end
    if (cmd.emit_sign) begin
      glyph.character <= b2da_pkg::ASCII_MINUS;
      glyph.last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      glyph.character <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(top_digit);
      glyph.last      <= status.one_left;
    end
  end

  assign status.conv_done = (bitcnt == BIT_W'(b2da_pkg::MAG_W - 1));
  assign status.one_left  = (remaining == CNT_W'(1));
  assign status.can_skip  = (top_digit == '0) && !status.one_left && !ovf;
  assign status.out_free  = !glyph_valid || !glyph_stall;
  assign status.negative  = negative;

endmodule

[rtl/b2da_ctrl.sv]
// Controller state machine of the converter: sequences conversion, leading
// zero removal and character emission. Uses b2da_pkg.
module b2da_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              num_valid,
  output logic              num_stall,
  input  b2da_pkg::status_t status,
  output b2da_pkg::cmd_t    cmd
);

  b2da_pkg::state_t state;
  b2da_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b2da_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    num_stall  = 1'b1;
    case (state)
      b2da_pkg::ST_IDLE: begin
        num_stall = 1'b0;
        if (num_valid) begin
          cmd.load   = 1'b1;
          state_next = b2da_pkg::ST_CONV;
        end
      end
      b2da_pkg::ST_CONV: begin
        cmd.shift_bit = 1'b1;
        if (status.conv_done) begin
          state_next = b2da_pkg::ST_SKIP;
        end
      end
      b2da_pkg::ST_SKIP: begin
        if (status.can_skip) begin
          cmd.skip_zero = 1'b1;
        end else if (status.negative) begin
          state_next = b2da_pkg::ST_SIGN;
        end else begin
          state_next = b2da_pkg::ST_DIGITS;
        end
      end
      b2da_pkg::ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = b2da_pkg::ST_DIGITS;
        end
      end
      b2da_pkg::ST_DIGITS: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.one_left) begin
            state_next = b2da_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = b2da_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/binary_to_decimal_ascii.sv]
// Binary to decimal ASCII converter: one number in, 1 to 11 characters out.
// The first character is offered after the number's transfer once the bit-serial
// double-dabble steps, the dropping of leading zeros, a decision step and the
// output load are done, then one character per cycle without stalls. A new number
// is taken only once the last character of the previous one is in the output
// register. Synchronous active-high reset idles the FSM and output.
module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = b2da_pkg::DEF_MAX_DIGITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             num_valid,
  output logic             num_stall,
  input  b2da_pkg::num_t   num,
  output logic             glyph_valid,
  input  logic             glyph_stall,
  output b2da_pkg::glyph_t glyph
);

  `include "assert_macros.svh"

  // The digit buffer never needs more than ten places for a 32-bit value, and
  // always holds at least one. With fewer places, only the low digits are
  // kept and a value that overflows them is printed with its inner zeros.
  localparam int NUM_DIGITS = (MAX_DIGITS > b2da_pkg::HW_DIGITS) ? b2da_pkg::HW_DIGITS :
                              ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);

  b2da_pkg::cmd_t    cmd;
  b2da_pkg::status_t status;
  logic              glyph_is_sign;
  logic              glyph_is_char;

  // The controller takes a number only when idle. The final character sits
  // in the output register, so a new number may be taken while that last
  // transfer is still stalled.
  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath converts with shift-and-add-3, then shifts digits out from
  // the top of the BCD register, most significant first.
  b2da_datapath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .num         (num),
    .cmd         (cmd),
    .status      (status),
    .glyph_valid (glyph_valid),
    .glyph_stall (glyph_stall),
    .glyph       (glyph)
  );

  // Classification of the character in the output register.
  assign glyph_is_sign = (glyph.character == b2da_pkg::ASCII_MINUS);
  assign glyph_is_char = glyph_is_sign ||
                         ((glyph.character >= b2da_pkg::ASCII_ZERO) &&
                          (glyph.character <= b2da_pkg::ASCII_NINE));

  // Every character shown is a minus sign or a decimal digit.
  `B2DA_ASSERT(a_char_range, glyph_valid |-> glyph_is_char)
  // A minus sign is never the last character of a number.
  `B2DA_ASSERT(a_sign_not_last, (glyph_valid && glyph_is_sign) |-> !glyph.last)
  // In the cycle after a number is taken the converter is busy.
  `B2DA_ASSERT_NEXT(a_busy_after_accept, num_valid && !num_stall, num_stall)

endmodule

[bench/tb_binary_to_decimal_ascii.sv]
// Self-checking testbench for binary_to_decimal_ascii: drives numbers in both modes
// and checks every emitted character against an in-bench decimal predictor.
// Depends on b2da_pkg and the binary_to_decimal_ascii RTL.
module tb_binary_to_decimal_ascii;

  // The block is built with its default digit buffer.
  // The predictor clamps that size the same way the hardware does.
  localparam int BUF_DIGITS = b2da_pkg::DEF_MAX_DIGITS;
  localparam int DIGIT_CAP = (BUF_DIGITS > b2da_pkg::HW_DIGITS) ? b2da_pkg::HW_DIGITS :
                             ((BUF_DIGITS < 1) ? 1 : BUF_DIGITS);
  localparam int RADIX = 10;

  // No transfer can be missing for this many cycles in a correct run. The limit
  // covers one whole number plus the gaps from random idling.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settling time after the last character: a bit more than one full conversion.
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS = 40;
  localparam int IDLE_PCT = 28;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             num_valid = 1'b0;
  logic             num_stall;
  b2da_pkg::num_t   num = '0;
  logic             glyph_valid;
  logic             glyph_stall = 1'b0;
  b2da_pkg::glyph_t glyph;

  // Characters still owed by the block, oldest first.
  b2da_pkg::glyph_t expected_glyphs[$];

  int error_count = 0;
  int numbers_sent = 0;
  int negatives_sent = 0;
  int glyphs_checked = 0;
  int quiet_cycles = 0;

  // Idle rates of the sender and the receiver, in percent of cycles.
  int send_gap_pct = IDLE_PCT;
  int stall_pct = IDLE_PCT;

  binary_to_decimal_ascii #(
    .MAX_DIGITS(BUF_DIGITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .num_valid(num_valid),
    .num_stall(num_stall),
    .num(num),
    .glyph_valid(glyph_valid),
    .glyph_stall(glyph_stall),
    .glyph(glyph)
  );

  always #5 clk = ~clk;

  // Predicts the characters of one accepted number. Digits are peeled off
  // least significant first; a zero magnitude still gives one digit. When the
  // buffer is smaller than the number, only the low digits survive, zeros
  // included. The sign, if any, goes out first and is never the last one.
  function automatic void predict_glyphs(input b2da_pkg::num_t item);
    logic [3:0]       digit_buf [b2da_pkg::HW_DIGITS];
    logic [31:0]      rest;
    int               ndig;
    b2da_pkg::glyph_t g;
    rest = item.magnitude;
    ndig = 0;
    do begin
      digit_buf[ndig] = 4'(rest % RADIX);
      rest = rest / RADIX;
      ndig++;
    end while (rest != 0 && ndig < DIGIT_CAP);
    if (item.action) begin
      g.character = b2da_pkg::ASCII_MINUS;
      g.last = 1'b0;
      expected_glyphs.push_back(g);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      g.character = b2da_pkg::ASCII_ZERO + {4'd0, digit_buf[i]};
      g.last = (i == 0);
      expected_glyphs.push_back(g);
    end
  endfunction

  // Offers one number and returns at the edge where its transfer happens. The
  // caller is always at a rising edge, so valid gets one assignment per step.
  task automatic send_number(input logic action, input logic [31:0] magnitude);
    b2da_pkg::num_t item;
    item.action = action;
    item.magnitude = magnitude;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      num_valid <= 1'b0;
      @(posedge clk);
    end
    num_valid <= 1'b1;
    num <= item;
    do @(posedge clk); while (num_stall);
    predict_glyphs(item);
    numbers_sent++;
    if (action) negatives_sent++;
  endtask

  // A magnitude with a random number of decimal digits, so that short numbers
  // are as common as long ones. One in four is drawn from the whole range.
  function automatic logic [31:0] random_magnitude();
    longint lo;
    longint hi;
    int     ndig;
    if ($urandom_range(3) == 0) return $urandom;
    ndig = $urandom_range(b2da_pkg::HW_DIGITS, 1);
    lo = 1;
    for (int i = 1; i < ndig; i++) lo = lo * RADIX;
    hi = lo * RADIX - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return $urandom_range(32'(hi), 32'(lo));
  endfunction

  // Some digit-count boundaries, zero, the extremes and alternating bit patterns;
  // each corner value in both modes so zero shows up with and without a sign.
  task automatic test_directed();
    logic [31:0] corner [11];
    corner = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1005,
               32'd999999999, 32'd1000000000, 32'd2147483648, 32'hFFFF_FFFF};
    foreach (corner[i]) begin
      send_number(1'b0, corner[i]);
      send_number(1'b1, corner[i]);
    end
    send_number(1'b0, 32'hAAAA_AAAA);
    send_number(1'b1, 32'h5555_5555);
  endtask

  task automatic test_random_numbers(input int count);
    for (int i = 0; i < count; i++) begin
      send_number(1'($urandom_range(1)), random_magnitude());
    end
  endtask

  // The sender holds off until the block has emitted everything it owes, so
  // the next number lands on a fully idle converter.
  task automatic test_drain_then_resume(input int count);
    num_valid <= 1'b0;
    @(posedge clk);
    while (expected_glyphs.size() != 0) @(posedge clk);
    test_random_numbers(count);
  endtask

  // Neither side idles: numbers follow each other and characters flow at full rate.
  task automatic test_back_to_back(input int count);
    send_gap_pct = 0;
    stall_pct = 0;
    test_random_numbers(count);
    send_gap_pct = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  // Checks each character transfer against the oldest prediction and drives
  // the receiver's stall for the next cycle.
  always @(posedge clk) begin
    b2da_pkg::glyph_t want;
    if (!rst && glyph_valid && !glyph_stall) begin
      if (expected_glyphs.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected character: expected none, got char %0d last %0b",
                   $time, glyph.character, glyph.last);
      end else begin
        want = expected_glyphs.pop_front();
        glyphs_checked++;
        if (glyph.character !== want.character) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: character mismatch: expected %0d, got %0d",
                     $time, want.character, glyph.character);
        end
        if (glyph.last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: last flag mismatch: expected %0b, got %0b",
                     $time, want.last, glyph.last);
        end
      end
    end
    glyph_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((num_valid && !num_stall) || (glyph_valid && !glyph_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d characters outstanding",
               $time, quiet_cycles, expected_glyphs.size());
      $display("[binary_to_decimal_ascii] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_numbers(90);
    test_drain_then_resume(10);
    test_back_to_back(30);
    test_random_numbers(20);

    num_valid <= 1'b0;
    @(posedge clk);
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_glyphs.size() != 0) begin
      error_count++;
      $display("%0t: %0d characters never arrived", $time, expected_glyphs.size());
    end

    $display("Converted %0d numbers (%0d with a minus sign) into %0d checked characters,",
             numbers_sent, negatives_sent, glyphs_checked);
    $display("covering zero, digit-count boundaries, full range, stalls and full-rate flow.");
    if (error_count == 0) begin
      $display("[binary_to_decimal_ascii] OK");
    end else begin
      $display("[binary_to_decimal_ascii] ERROR");
    end
    $finish;
  end

endmodule
